[rtl/core/gif_lzw_decoder_top_defines.svh]
// Assertion macros for the GIF LZW decoder checker.
`ifndef GIF_LZW_DECODER_TOP_DEFINES_SVH
`define GIF_LZW_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define GLZW_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define GLZW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/glzw_pkg.sv]
// ----------------------------------------------------------------------------
// glzw_pkg
// Shared types and constants of the GIF LZW decoder.
// ----------------------------------------------------------------------------
package glzw_pkg;

  localparam int MaxCodeBits = 12;
  localparam int BitBufBits  = 32;
  localparam int DictAw      = 12;
  localparam int StackAw     = 12;

  typedef enum logic [1:0] {
    ACT_IDLE  = 2'd0,
    ACT_BYTE  = 2'd1,
    ACT_START = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_MIN  = 3'd1,
    PH_LEN  = 3'd2,
    PH_DATA = 3'd3,
    PH_DONE = 3'd4,
    PH_ERR1 = 3'd5,
    PH_ERR2 = 3'd6,
    PH_ERR3 = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_MIN_SIZE = 2'd1,
    ERR_CODE     = 2'd2,
    ERR_TRUNC    = 2'd3
  } err_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEC,
    S_FP,
    S_FC,
    S_WALK,
    S_ADD,
    S_POP,
    S_POPW,
    S_FIN
  } seq_e;

  typedef struct packed {
    logic [11:0] prefix;
    logic [7:0]  suffix;
    logic [7:0]  first;
  } dict_entry_t;

endpackage

[rtl/core/glzw_ram.sv]
// ----------------------------------------------------------------------------
// glzw_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module glzw_ram #(
  parameter int Width = 8,
  parameter int Aw    = 12
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [2**Aw];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

[rtl/core/gif_lzw_decoder_top.sv]
// ----------------------------------------------------------------------------
// gif_lzw_decoder_top
// GIF LZW image-data decoder: unpacks LSB-first codes, expands them through
// a prefix/suffix dictionary onto a pixel stack, one result per item.
// ----------------------------------------------------------------------------
//
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------------
//  in      | in_valid_i/in_ready_o  | action_i, data_byte_i
//  out     | out_valid_o/out_ready_i| pixel_valid_o, pixel_index_o, byte_taken_o,
//          |                        | image_done_o, error_code_o
//
//  An item with no code to decode passes the pop and finish states (plus a
//  wait for the stack RAM read when a pixel pops); a start item is answered
//  from idle. Clear, end, first or refused codes add the decode state; a
//  string code adds first-prefix, first-code (not if it equals the next free
//  code), walk (one symbol per cycle via the dictionary RAM's single port)
//  and add states. Reset clears all control state; the dictionary and stack RAMs
//  are not cleared. A stalled result holds the output register and blocks input.
module gif_lzw_decoder_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           action_i,
  input  logic [7:0]           data_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 pixel_valid_o,
  output logic [7:0]           pixel_index_o,
  output logic                 byte_taken_o,
  output logic                 image_done_o,
  output logic [1:0]           error_code_o
);
  import glzw_pkg::*;

  localparam int DictW = $bits(dict_entry_t);

  seq_e        state_q, state_d;
  phase_e      phase_q, phase_d;
  logic [12:0] stk_cnt_q, stk_cnt_d;
  logic [BitBufBits-1:0] buf_q, buf_d;
  logic [5:0]  bcnt_q, bcnt_d;
  logic [3:0]  cw_q, cw_d;
  logic [12:0] nfc_q, nfc_d;
  logic [11:0] prev_q, prev_d;
  logic        pvld_q, pvld_d;
  logic [3:0]  root_q, root_d;
  logic [7:0]  sb_q, sb_d;

  // per-item working registers
  action_e     act_q, act_d;
  logic [7:0]  byte_q, byte_d;
  logic [11:0] code_q, code_d;
  logic [7:0]  first_q, first_d;
  logic [7:0]  fp_q, fp_d;
  logic [11:0] walk_q, walk_d;

  // output register
  logic        ovld_q, ovld_d;
  logic        pv_q, pv_d;
  logic [7:0]  pix_q, pix_d;
  logic        taken_q, taken_d;
  logic        done_q, done_d;
  err_e        err_q, err_d;

  // RAM ports
  logic               dict_we;
  logic [DictAw-1:0]  dict_addr;
  dict_entry_t        dict_wdata, dict_rdata;
  logic [DictW-1:0]   dict_rraw;
  logic               stk_we;
  logic [StackAw-1:0] stk_addr;
  logic [7:0]         stk_wdata, stk_rdata;

  logic        accept;
  logic [12:0] clear_code;
  logic [12:0] code_mask;
  logic [11:0] dec_code;
  logic        dec_ready;
  logic        dec_normal;
  logic        walk_more;
  logic [12:0] code_ext;

  assign in_ready_o = (state_q == S_IDLE) && !ovld_q;
  assign accept     = in_valid_i && in_ready_o;

  // clear code follows the low three bits of the root width
  assign clear_code = 13'd1 << root_q[2:0];
  assign code_mask  = (13'd1 << cw_q) - 13'd1;
  assign dec_code   = buf_q[11:0] & code_mask[11:0];
  assign code_ext   = {1'b0, dec_code};
  assign dec_ready  = ((phase_q == PH_LEN) || (phase_q == PH_DATA)) && (stk_cnt_q == 13'd0)
                   && (cw_q != 4'd0) && ({2'b00, bcnt_q} >= {4'd0, cw_q});
  // an ordinary code that expands through the dictionary
  assign dec_normal = (code_ext != clear_code) && (code_ext != clear_code + 13'd1)
                   && pvld_q && (code_ext <= nfc_q);
  assign walk_more  = {1'b0, walk_q} >= clear_code + 13'd2;

  assign dict_rdata = dict_entry_t'(dict_rraw);

  glzw_ram #(.Width(DictW), .Aw(DictAw)) u_dict (
    .clk_i   (clk_i),
    .we_i    (dict_we),
    .addr_i  (dict_addr),
    .wdata_i (dict_wdata),
    .rdata_o (dict_rraw)
  );

  glzw_ram #(.Width(8), .Aw(StackAw)) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .addr_i  (stk_addr),
    .wdata_i (stk_wdata),
    .rdata_o (stk_rdata)
  );

  // Sequencer: next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (action_e'(action_i) == ACT_START) begin
            state_d = S_IDLE;
          end else if (dec_ready) begin
            state_d = S_DEC;
          end else begin
            state_d = S_POP;
          end
        end
      end
      S_DEC:  state_d = dec_normal ? S_FP : S_POP;
      S_FP:   state_d = ({1'b0, code_q} == nfc_q) ? S_WALK : S_FC;
      S_FC:   state_d = S_WALK;
      S_WALK: state_d = walk_more ? S_WALK : S_ADD;
      S_ADD:  state_d = S_POP;
      S_POP:  state_d = (stk_cnt_q != 13'd0) ? S_POPW : S_FIN;
      S_POPW: state_d = S_FIN;
      S_FIN:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer: datapath and RAM control.
  always_comb begin
    logic [12:0] nfc_inc;
    logic        push;
    logic [7:0]  push_val;
    phase_e      ph;

    phase_d  = phase_q;
    stk_cnt_d = stk_cnt_q;
    buf_d    = buf_q;
    bcnt_d   = bcnt_q;
    cw_d     = cw_q;
    nfc_d    = nfc_q;
    prev_d   = prev_q;
    pvld_d   = pvld_q;
    root_d   = root_q;
    sb_d     = sb_q;
    act_d    = act_q;
    byte_d   = byte_q;
    code_d   = code_q;
    first_d  = first_q;
    fp_d     = fp_q;
    walk_d   = walk_q;
    ovld_d   = ovld_q && !out_ready_i;
    pv_d     = pv_q;
    pix_d    = pix_q;
    taken_d  = taken_q;
    done_d   = done_q;
    err_d    = err_q;

    dict_we    = 1'b0;
    dict_addr  = prev_q;
    dict_wdata = '{prefix: prev_q, suffix: first_q, first: fp_q};
    push       = 1'b0;
    push_val   = 8'd0;
    nfc_inc    = nfc_q + 13'd1;
    ph         = phase_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          act_d  = action_e'(action_i);
          byte_d = data_byte_i;
          if (action_e'(action_i) == ACT_START) begin
            // restart: clear decoder state and answer at once
            phase_d   = PH_MIN;
            stk_cnt_d = 13'd0;
            buf_d     = '0;
            bcnt_d    = 6'd0;
            cw_d      = 4'd0;
            nfc_d     = 13'd0;
            prev_d    = 12'd0;
            pvld_d    = 1'b0;
            root_d    = 4'd0;
            sb_d      = 8'd0;
            ovld_d    = 1'b1;
            pv_d      = 1'b0;
            pix_d     = 8'd0;
            taken_d   = 1'b0;
            done_d    = 1'b0;
            err_d     = ERR_NONE;
          end
        end
      end
      S_DEC: begin
        // take one code off the bottom of the bit buffer
        code_d = dec_code;
        buf_d  = buf_q >> cw_q;
        bcnt_d = bcnt_q - {2'b00, cw_q};
        if (code_ext == clear_code) begin
          nfc_d  = clear_code + 13'd2;
          cw_d   = root_q + 4'd1;
          pvld_d = 1'b0;
        end else if (code_ext == clear_code + 13'd1) begin
          phase_d = PH_DONE;
        end else if (!pvld_q) begin
          if (code_ext >= clear_code) begin
            phase_d = PH_ERR2;
          end else begin
            push     = 1'b1;
            push_val = dec_code[7:0];
            prev_d   = dec_code;
            pvld_d   = 1'b1;
          end
        end else if (code_ext > nfc_q) begin
          phase_d = PH_ERR2;
        end else begin
          dict_addr = prev_q;
        end
      end
      S_FP: begin
        fp_d = ({1'b0, prev_q} < clear_code) ? prev_q[7:0] : dict_rdata.first;
        if ({1'b0, code_q} == nfc_q) begin
          // code not yet in the table: previous string plus its first symbol
          first_d   = fp_d;
          push      = 1'b1;
          push_val  = fp_d;
          walk_d    = prev_q;
          dict_addr = prev_q;
        end else begin
          dict_addr = code_q;
        end
      end
      S_FC: begin
        first_d   = ({1'b0, code_q} < clear_code) ? code_q[7:0] : dict_rdata.first;
        walk_d    = code_q;
        dict_addr = code_q;
      end
      S_WALK: begin
        // one chain link per cycle, last symbol pushed first
        push = 1'b1;
        if (walk_more) begin
          push_val  = dict_rdata.suffix;
          walk_d    = dict_rdata.prefix;
          dict_addr = dict_rdata.prefix;
        end else begin
          push_val = walk_q[7:0];
        end
      end
      S_ADD: begin
        if (nfc_q < 13'd4096) begin
          dict_we   = 1'b1;
          dict_addr = nfc_q[DictAw-1:0];
          nfc_d     = nfc_inc;
          if ((nfc_inc == (13'd1 << cw_q)) && (cw_q < 4'(MaxCodeBits))) begin
            cw_d = cw_q + 4'd1;
          end
        end
        prev_d = code_q;
      end
      S_POP: begin
        if (stk_cnt_q != 13'd0) begin
          stk_cnt_d = stk_cnt_q - 13'd1;
          pv_d      = 1'b1;
        end else begin
          pv_d  = 1'b0;
          pix_d = 8'd0;
        end
      end
      S_POPW: begin
        pix_d = stk_rdata;
      end
      S_FIN: begin
        taken_d = 1'b0;
        if (act_q == ACT_BYTE) begin
          case (phase_q)
            PH_MIN: begin
              taken_d = 1'b1;
              if ((byte_q >= 8'd2) && (byte_q <= 8'd8)) begin
                root_d  = byte_q[3:0];
                cw_d    = byte_q[3:0] + 4'd1;
                nfc_d   = (13'd1 << byte_q[3:0]) + 13'd2;
                pvld_d  = 1'b0;
                ph      = PH_LEN;
              end else begin
                ph = PH_ERR1;
              end
            end
            PH_LEN: begin
              // hold the length byte while a whole code is still buffered
              if ({2'b00, bcnt_q} < {4'd0, cw_q}) begin
                taken_d = 1'b1;
                if (byte_q == 8'd0) begin
                  ph = PH_ERR3;
                end else begin
                  sb_d = byte_q;
                  ph   = PH_DATA;
                end
              end
            end
            PH_DATA: begin
              if ({1'b0, bcnt_q} + 7'd8 <= 7'(BitBufBits)) begin
                taken_d = 1'b1;
                buf_d   = buf_q | ({{(BitBufBits-8){1'b0}}, byte_q} << bcnt_q);
                bcnt_d  = bcnt_q + 6'd8;
                sb_d    = sb_q - 8'd1;
                if (sb_q == 8'd1) begin
                  ph = PH_LEN;
                end
              end
            end
            PH_IDLE: taken_d = 1'b0;
            default: taken_d = 1'b1;
          endcase
        end
        phase_d = ph;
        ovld_d  = 1'b1;
        done_d  = (ph == PH_DONE) && (stk_cnt_q == 13'd0);
        case (ph)
          PH_ERR1: err_d = ERR_MIN_SIZE;
          PH_ERR2: err_d = ERR_CODE;
          PH_ERR3: err_d = ERR_TRUNC;
          default: err_d = ERR_NONE;
        endcase
      end
      default: begin
      end
    endcase

    // stack port: pushes write at the count, pops read below it
    stk_we    = 1'b0;
    stk_wdata = push_val;
    stk_addr  = (state_q == S_POP) ? (stk_cnt_q[StackAw-1:0] - 12'd1)
                                   : stk_cnt_q[StackAw-1:0];
    if (push && (stk_cnt_q < 13'd4096)) begin
      stk_we    = 1'b1;
      stk_cnt_d = stk_cnt_q + 13'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      phase_q   <= PH_IDLE;
      stk_cnt_q <= 13'd0;
      buf_q     <= '0;
      bcnt_q    <= 6'd0;
      cw_q      <= 4'd0;
      nfc_q     <= 13'd0;
      prev_q    <= 12'd0;
      pvld_q    <= 1'b0;
      root_q    <= 4'd0;
      sb_q      <= 8'd0;
      ovld_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      stk_cnt_q <= stk_cnt_d;
      buf_q     <= buf_d;
      bcnt_q    <= bcnt_d;
      cw_q      <= cw_d;
      nfc_q     <= nfc_d;
      prev_q    <= prev_d;
      pvld_q    <= pvld_d;
      root_q    <= root_d;
      sb_q      <= sb_d;
      ovld_q    <= ovld_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    act_q   <= act_d;
    byte_q  <= byte_d;
    code_q  <= code_d;
    first_q <= first_d;
    fp_q    <= fp_d;
    walk_q  <= walk_d;
    pv_q    <= pv_d;
    pix_q   <= pix_d;
    taken_q <= taken_d;
    done_q  <= done_d;
    err_q   <= err_d;
  end

  assign out_valid_o   = ovld_q;
  assign pixel_valid_o = pv_q;
  assign pixel_index_o = pix_q;
  assign byte_taken_o  = taken_q;
  assign image_done_o  = done_q;
  assign error_code_o  = err_q;

endmodule

[rtl/core/glzw_checker.sv]
// ----------------------------------------------------------------------------
// glzw_checker
// Port-level checks of the GIF LZW decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "gif_lzw_decoder_top_defines.svh"

module glzw_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       pixel_valid_o,
  input logic [7:0] pixel_index_o,
  input logic       image_done_o,
  input logic [1:0] error_code_o
);

  `GLZW_ASSERT(a_no_ready_with_result, out_valid_o, !in_ready_o, "input taken over a result")
  `GLZW_ASSERT_NEXT(a_busy_after_transfer, in_valid_i && in_ready_o, !in_ready_o, "ready after transfer")
  `GLZW_ASSERT_NEXT(a_result_holds, out_valid_o && !out_ready_i, out_valid_o && $stable(pixel_index_o), "result dropped")
  `GLZW_ASSERT(a_no_pixel_zero, out_valid_o && !pixel_valid_o, pixel_index_o == 8'd0, "stray pixel index")
  `GLZW_ASSERT(a_done_no_error, out_valid_o && image_done_o, error_code_o == 2'd0, "done with error")

endmodule

bind gif_lzw_decoder_top glzw_checker u_glzw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .pixel_valid_o (pixel_valid_o),
  .pixel_index_o (pixel_index_o),
  .image_done_o  (image_done_o),
  .error_code_o  (error_code_o)
);
